// ===== rtl/prefix_code_bit_decoder_unit_defines.svh =====
// Assertion macros shared by the prefix code bit decoder RTL.
`ifndef PREFIX_CODE_BIT_DECODER_UNIT_DEFINES_SVH
`define PREFIX_CODE_BIT_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define PCBD_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("pcbd assertion failed");
`define PCBD_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("pcbd assertion failed");
`define PCBD_ASSERT_NEVER(lbl, clk, rst_n, a) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
		else $error("pcbd assertion failed");
`else
`define PCBD_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define PCBD_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`define PCBD_ASSERT_NEVER(lbl, clk, rst_n, a)
`endif

`endif

// ===== rtl/pcbd_pkg.sv =====
// Types, constants and control interface of the prefix code bit decoder.
package pcbd_pkg;

	localparam int DEF_TABLE_ENTRIES = 256;
	localparam int DEF_MAX_CODE_LEN  = 16;
	localparam int BYTE_BITS         = 8;

	localparam int IDX_W  = 8;
	localparam int CODE_W = 16;
	localparam int LEN_W  = 5;
	localparam int SYM_W  = 8;
	localparam int CNT_W  = 4;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_DATA = 1'b1;

	typedef struct packed {
		logic                 mode;
		logic [IDX_W-1:0]     entry_index;
		logic [CODE_W-1:0]    code_bits;
		logic [LEN_W-1:0]     code_length;
		logic [SYM_W-1:0]     entry_symbol;
		logic [BYTE_BITS-1:0] data_byte;
		logic [CNT_W-1:0]     bit_count;
		logic                 stream_end;
	} item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             error;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		logic [SYM_W-1:0]  sym;
	} tab_entry_t;

	typedef struct packed {
		logic accept;
		logic shift_bit;
		logic scan_start;
		logic scan_step;
		logic capture;
		logic capture_err;
		logic promote;
		logic push_last;
		logic finish_clear;
	} dp_cmd_t;

	typedef struct packed {
		logic is_data;
		logic bits_left;
		logic hit;
		logic scan_end;
		logic plen_full;
		logic pend_valid;
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/pcbd_ctrl.sv =====
// Sequencer for the prefix code bit decoder: per-bit shift, table scan, result hand-off.
module pcbd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  pcbd_pkg::dp_status_t status,
	output pcbd_pkg::dp_cmd_t    cmd
);
	import pcbd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_SCAN,
		ST_RESULT,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.accept = 1'b1;
					if (status.is_data) begin
						state_d = ST_SHIFT;
					end
				end
			end
			ST_SHIFT: begin
				if (status.bits_left) begin
					cmd.shift_bit  = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.hit) begin
					cmd.capture = 1'b1;
					state_d     = ST_RESULT;
				end else if (status.scan_end) begin
					if (status.plen_full) begin
						cmd.capture     = 1'b1;
						cmd.capture_err = 1'b1;
						state_d         = ST_RESULT;
					end else begin
						state_d = ST_SHIFT;
					end
				end
			end
			ST_RESULT: begin
				if (!status.pend_valid || status.out_free) begin
					cmd.promote = 1'b1;
					state_d     = ST_SHIFT;
				end
			end
			ST_FINISH: begin
				cmd.finish_clear = 1'b1;
				if (!status.pend_valid) begin
					state_d = ST_IDLE;
				end else if (status.out_free) begin
					cmd.push_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = (state_q != ST_IDLE);

endmodule

// ===== rtl/pcbd_datapath.sv =====
// Datapath of the prefix code bit decoder: code table, partial code, scan compare, result regs.
`include "prefix_code_bit_decoder_unit_defines.svh"

module pcbd_datapath #(
	parameter int TABLE_ENTRIES = pcbd_pkg::DEF_TABLE_ENTRIES,
	parameter int MAX_CODE_LEN  = pcbd_pkg::DEF_MAX_CODE_LEN
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcbd_pkg::item_t      item,
	input  logic                 result_stall,
	output logic                 result_valid,
	output pcbd_pkg::result_t    result,
	input  pcbd_pkg::dp_cmd_t    cmd,
	output pcbd_pkg::dp_status_t status
);
	import pcbd_pkg::*;

	localparam int IW   = $clog2(TABLE_ENTRIES);
	localparam int PTRW = $clog2(TABLE_ENTRIES + 1);
	localparam int PW   = MAX_CODE_LEN;
	localparam int LW   = $clog2(PW + 1);
	localparam int CMPW = (LW > LEN_W) ? LW : LEN_W;
	localparam int CW   = (PW > CODE_W) ? PW : CODE_W;

	tab_entry_t tab_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] tab_vld_q;

	tab_entry_t rd_s1;
	logic       rd_vld_s1;
	logic       ent_vld_s1;

	logic [PTRW-1:0]      ptr_q;
	logic [PW-1:0]        part_q;
	logic [LW-1:0]        plen_q;
	logic [BYTE_BITS-1:0] data_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 end_q;

	result_t res_q;
	result_t pend_q;
	logic    pend_vld_q;
	result_t out_q;
	logic    out_vld_q;

	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	logic              rd_en;
	logic [IW-1:0]     rd_addr;
	logic [CNT_W-1:0]  cnt_sat;
	logic [CW-1:0]     code_mask;
	logic              hit;
	logic              out_free;
	logic              out_push;
	logic              clr_part;

	assign wr_en   = cmd.accept && (item.mode == MODE_LOAD) &&
	                 ({1'b0, item.entry_index} < (IDX_W + 1)'(TABLE_ENTRIES));
	assign wr_addr = item.entry_index[IW-1:0];
	assign rd_en   = cmd.scan_step && (ptr_q < PTRW'(TABLE_ENTRIES));
	assign rd_addr = ptr_q[IW-1:0];

	assign cnt_sat = (item.bit_count > CNT_W'(BYTE_BITS)) ? CNT_W'(BYTE_BITS) : item.bit_count;

	assign code_mask = ~({CW{1'b1}} << rd_s1.len);
	assign hit = rd_vld_s1 && ent_vld_s1 && (rd_s1.len != '0) &&
	             (CMPW'(rd_s1.len) == CMPW'(plen_q)) &&
	             ((CW'(rd_s1.code) & code_mask) == CW'(part_q));

	assign out_free = !out_vld_q || !result_stall;
	assign out_push = (cmd.promote && pend_vld_q) || cmd.push_last;
	assign clr_part = cmd.capture || (cmd.finish_clear && end_q);

	// table storage, single write and single registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tab_mem[wr_addr] <= '{code: item.code_bits, len: item.code_length,
			                      sym: item.entry_symbol};
		end
		if (rd_en) begin
			rd_s1 <= tab_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_vld_q  <= '0;
			ent_vld_s1 <= 1'b0;
			rd_vld_s1  <= 1'b0;
			ptr_q      <= '0;
			part_q     <= '0;
			plen_q     <= '0;
			cnt_q      <= '0;
			end_q      <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				tab_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.scan_start) begin
				ptr_q     <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				rd_vld_s1 <= rd_en;
				if (rd_en) begin
					ptr_q      <= ptr_q + PTRW'(1);
					ent_vld_s1 <= tab_vld_q[rd_addr];
				end
			end
			if (cmd.accept && (item.mode == MODE_DATA)) begin
				cnt_q <= cnt_sat;
				end_q <= item.stream_end;
			end else if (cmd.shift_bit) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (clr_part) begin
				part_q <= '0;
				plen_q <= '0;
			end else if (cmd.shift_bit) begin
				part_q <= {part_q[PW-2:0], data_q[BYTE_BITS-1]};
				plen_q <= plen_q + LW'(1);
			end
			if (cmd.promote) begin
				pend_vld_q <= 1'b1;
			end else if (cmd.push_last) begin
				pend_vld_q <= 1'b0;
			end
			if (out_push) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (item.mode == MODE_DATA)) begin
			data_q <= item.data_byte << (CNT_W'(BYTE_BITS) - cnt_sat);
		end else if (cmd.shift_bit) begin
			data_q <= data_q << 1;
		end
		if (cmd.capture) begin
			res_q <= '{symbol: cmd.capture_err ? '0 : rd_s1.sym,
			           error: cmd.capture_err, last: 1'b0};
		end
		if (cmd.promote) begin
			pend_q <= res_q;
		end
		if (out_push) begin
			out_q <= '{symbol: pend_q.symbol, error: pend_q.error, last: cmd.push_last};
		end
	end

	assign status = '{
		is_data:    (item.mode == MODE_DATA),
		bits_left:  (cnt_q != '0),
		hit:        hit,
		scan_end:   (ptr_q == PTRW'(TABLE_ENTRIES)),
		plen_full:  (plen_q == LW'(PW)),
		pend_valid: pend_vld_q,
		out_free:   out_free
	};

	assign result_valid = out_vld_q;
	assign result       = out_q;

	`PCBD_ASSERT_NEVER(a_plen_range, clk, arst_n, plen_q > LW'(PW))
	`PCBD_ASSERT_IMP(a_push_when_free, clk, arst_n, out_push, out_free)
	`PCBD_ASSERT_NEXT(a_capture_clears, clk, arst_n, cmd.capture, plen_q == '0)
	`PCBD_ASSERT_IMP(a_shift_has_bits, clk, arst_n, cmd.shift_bit, cnt_q != '0)

endmodule

// ===== rtl/prefix_code_bit_decoder_unit.sv =====
// Prefix code (Huffman) bit-serial decoder: top level joining sequencer and datapath.
// A load transaction writes one code table slot. A data transaction decodes its bits
// one at a time; each bit is shifted into the partial code, then the code table is scanned
// linearly through its single read port, stopping early when a slot matches, and a result,
// when one is produced, is handed on in a result state. Results leave through a one-entry
// output register; the last result of a transaction is held back until the byte is finished
// so that its last flag is exact.
// While a result is pending and the output register is stalled, decoding waits.
// The table comes out of reset empty; no clearing pass is needed.
module prefix_code_bit_decoder_unit #(
	parameter int TABLE_ENTRIES = pcbd_pkg::DEF_TABLE_ENTRIES,
	parameter int MAX_CODE_LEN  = pcbd_pkg::DEF_MAX_CODE_LEN
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  pcbd_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output pcbd_pkg::result_t result
);
	import pcbd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	pcbd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	pcbd_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_CODE_LEN  (MAX_CODE_LEN)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

// ===== verif/tb_prefix_code_bit_decoder_unit.sv =====
// Self-checking testbench for the prefix code bit decoder: directed and random streams.
`timescale 1ns / 1ps

module tb_prefix_code_bit_decoder_unit;
	import pcbd_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int      send_idle_pct = 0;
	int      stall_pct = 0;
	int      sent_items = 0;
	int      fail_count = 0;

	// predictor state
	logic [CODE_W-1:0] slot_code [DEF_TABLE_ENTRIES];
	logic [LEN_W-1:0]  slot_len  [DEF_TABLE_ENTRIES];
	logic [SYM_W-1:0]  slot_sym  [DEF_TABLE_ENTRIES];
	logic [CODE_W-1:0] part_code = '0;
	logic [LEN_W-1:0]  part_len = '0;
	result_t           decoded_q[$];

	// current random code set and bit stream under construction
	int                leaf_code[$];
	int                leaf_len[$];
	bit                stream_bits[$];

	prefix_code_bit_decoder_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		foreach (slot_len[i]) begin
			slot_code[i] = '0;
			slot_len[i]  = '0;
			slot_sym[i]  = '0;
		end
	end

	function automatic void decode_transaction(input item_t it);
		result_t           res[8];
		int                n;
		int                nbits;
		logic [CODE_W-1:0] msk;
		bit                hit;
		logic [SYM_W-1:0]  hsym;
		if (it.mode == MODE_LOAD) begin
			slot_code[it.entry_index] = it.code_bits;
			slot_len[it.entry_index]  = it.code_length;
			slot_sym[it.entry_index]  = it.entry_symbol;
			return;
		end
		n = 0;
		nbits = (it.bit_count > BYTE_BITS) ? BYTE_BITS : int'(it.bit_count);
		for (int k = nbits - 1; k >= 0; k--) begin
			part_code = {part_code[CODE_W-2:0], it.data_byte[k]};
			part_len  = part_len + 1'b1;
			msk       = CODE_W'((32'd1 << part_len) - 32'd1);
			hit       = 1'b0;
			hsym      = '0;
			for (int s = 0; s < DEF_TABLE_ENTRIES; s++) begin
				if (!hit && slot_len[s] == part_len && (slot_code[s] & msk) == part_code) begin
					hit  = 1'b1;
					hsym = slot_sym[s];
				end
			end
			if (hit || part_len >= DEF_MAX_CODE_LEN) begin
				res[n].symbol = hit ? hsym : '0;
				res[n].error  = !hit;
				res[n].last   = 1'b0;
				n++;
				part_code = '0;
				part_len  = '0;
			end
		end
		if (it.stream_end) begin
			part_code = '0;
			part_len  = '0;
		end
		for (int i = 0; i < n; i++) begin
			res[i].last = (i == n - 1);
			decoded_q.push_back(res[i]);
		end
	endfunction

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (item_valid && !item_stall)
				decode_transaction(item);
			if (result_valid && !result_stall) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result: symbol %0h error %0b last %0b",
						result.symbol, result.error, result.last);
					fail_count++;
				end else begin
					want = decoded_q.pop_front();
					if (result.symbol !== want.symbol) begin
						$error("symbol: expected %0h, got %0h", want.symbol, result.symbol);
						fail_count++;
					end
					if (result.error !== want.error) begin
						$error("error: expected %0b, got %0b", want.error, result.error);
						fail_count++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, result.last);
						fail_count++;
					end
				end
			end
		end
	end

	task automatic send_item(input item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		sent_items++;
	endtask

	function automatic item_t noise_item();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(item_t)-1:0];
	endfunction

	task automatic load_slot(input logic [IDX_W-1:0] idx, input logic [CODE_W-1:0] code,
		input logic [LEN_W-1:0] len, input logic [SYM_W-1:0] sym);
		item_t it;
		it              = noise_item();
		it.mode         = MODE_LOAD;
		it.entry_index  = idx;
		it.code_bits    = code;
		it.code_length  = len;
		it.entry_symbol = sym;
		send_item(it);
	endtask

	task automatic send_data(input logic [BYTE_BITS-1:0] data, input logic [CNT_W-1:0] cnt,
		input logic fin);
		item_t it;
		it            = noise_item();
		it.mode       = MODE_DATA;
		it.data_byte  = data;
		it.bit_count  = cnt;
		it.stream_end = fin;
		send_item(it);
	endtask

	task automatic wait_drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
	endtask

	function automatic void split_leaf(input int idx);
		int c;
		int l;
		c = leaf_code[idx];
		l = leaf_len[idx];
		leaf_code[idx] = c << 1;
		leaf_len[idx]  = l + 1;
		leaf_code.push_back((c << 1) | 1);
		leaf_len.push_back(l + 1);
	endfunction

	function automatic void push_code(input int c, input int l);
		for (int k = l - 1; k >= 0; k--)
			stream_bits.push_back(((c >> k) & 1) != 0);
	endfunction

	task automatic test_empty_table();
		send_data(8'hFF, 4'd8, 1'b0);
		send_data(8'hFF, 4'd8, 1'b0);
		send_data(8'hAA, 4'd5, 1'b1);
	endtask

	task automatic test_table_rules();
		load_slot(8'd0, 16'hFFFF, 5'd16, 8'h00);
		send_data(8'hFF, 4'd15, 1'b0);
		send_data(8'hFF, 4'd9, 1'b1);
		load_slot(8'd0, 16'hFFFF, 5'd0, 8'hFF);
		load_slot(8'd64, 16'hFFFF, 5'd31, 8'h99);
		send_data(8'hFF, 4'd8, 1'b0);
		send_data(8'hFF, 4'd8, 1'b0);
		// same code in two slots: slot 1 must win over slot 255
		load_slot(8'd255, 16'h0006, 5'd3, 8'h77);
		load_slot(8'd1, 16'hFFFE, 5'd3, 8'hFF);
		load_slot(8'd5, 16'h1230, 5'd1, 8'hA5);
		load_slot(8'd200, 16'hFFF2, 5'd2, 8'h3C);
		load_slot(8'd128, 16'h0007, 5'd3, 8'h11);
		send_data(8'h5B, 4'd8, 1'b0);
		wait_drain();
		// partial code of two ones survives a load transaction
		load_slot(8'd9, 16'h0000, 5'd0, 8'h00);
		send_data(8'hFF, 4'd1, 1'b1);
	endtask

	task automatic test_bit_count_edges();
		send_data(8'hF3, 4'd2, 1'b0);
		send_data(8'hFF, 4'd0, 1'b1);
		send_data(8'hFE, 4'd1, 1'b0);
	endtask

	task automatic test_random_streams(input int n_items);
		int          stop_at;
		int          nsym;
		int          k;
		int          j;
		int          slot_of[$];
		bit          used[DEF_TABLE_ENTRIES];
		bit          gone;
		int          gone_code;
		int          gone_len;
		logic [7:0]  b;
		bit          fin;
		stop_at = sent_items + n_items;
		gone = 1'b0;
		gone_code = 0;
		gone_len = 0;
		leaf_code.delete();
		leaf_len.delete();
		while (sent_items < stop_at) begin
			if (leaf_len.size() == 0 || $urandom_range(0, 3) == 0) begin
				foreach (slot_of[i])
					if ($urandom_range(0, 3) != 0)
						load_slot(IDX_W'(slot_of[i]), CODE_W'($urandom), 5'd0, SYM_W'($urandom));
				if ($urandom_range(0, 2) == 0)
					load_slot(IDX_W'($urandom), CODE_W'($urandom), LEN_W'($urandom_range(17, 31)),
						SYM_W'($urandom));
				leaf_code.delete();
				leaf_len.delete();
				leaf_code.push_back(0);
				leaf_len.push_back(0);
				nsym = $urandom_range(2, 14);
				repeat (nsym - 1) begin
					k = $urandom_range(0, leaf_len.size() - 1);
					if (leaf_len[k] < DEF_MAX_CODE_LEN)
						split_leaf(k);
				end
				if (leaf_len[0] == 0)
					split_leaf(0);
				// occasionally a chain down to the longest code length
				if ($urandom_range(0, 5) == 0) begin
					k = leaf_len.size() - 1;
					while (leaf_len[k] < DEF_MAX_CODE_LEN) begin
						split_leaf(k);
						k = leaf_len.size() - 1;
					end
				end
				gone = 1'b0;
				if (leaf_len.size() > 2 && $urandom_range(0, 2) == 0) begin
					k = $urandom_range(0, leaf_len.size() - 1);
					gone      = 1'b1;
					gone_code = leaf_code[k];
					gone_len  = leaf_len[k];
					leaf_code.delete(k);
					leaf_len.delete(k);
				end
				foreach (used[i])
					used[i] = 1'b0;
				slot_of.delete();
				foreach (leaf_len[i]) begin
					do j = $urandom_range(0, DEF_TABLE_ENTRIES - 1); while (used[j]);
					used[j] = 1'b1;
					slot_of.push_back(j);
					load_slot(IDX_W'(j), (CODE_W'($urandom) << leaf_len[i]) | CODE_W'(leaf_code[i]),
						LEN_W'(leaf_len[i]), SYM_W'($urandom));
				end
			end else begin
				stream_bits.delete();
				repeat ($urandom_range(3, 24)) begin
					if (gone && $urandom_range(0, 9) == 0) begin
						// unused code: never matches, runs into the length limit
						push_code(gone_code, gone_len);
						repeat (DEF_MAX_CODE_LEN - gone_len)
							stream_bits.push_back($urandom_range(0, 1) != 0);
					end else begin
						k = $urandom_range(0, leaf_len.size() - 1);
						push_code(leaf_code[k], leaf_len[k]);
					end
				end
				while (stream_bits.size() > 0) begin
					k = (stream_bits.size() > BYTE_BITS) ? BYTE_BITS : stream_bits.size();
					b = '0;
					repeat (k)
						b = {b[6:0], stream_bits.pop_front()};
					b   = (8'($urandom) << k) | b;
					fin = (stream_bits.size() == 0) && ($urandom_range(0, 4) != 0);
					send_data(b, CNT_W'(k), fin);
				end
				if ($urandom_range(0, 5) == 0)
					repeat ($urandom_range(1, 3))
						send_item(noise_item());
			end
		end
	endtask

	initial begin
		int idle_tab[4];
		int stall_tab[4];
		idle_tab  = '{0, 85, 0, 37};
		stall_tab = '{0, 0, 85, 37};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_table_rules();
		test_bit_count_edges();
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_tab[p];
			stall_pct     = stall_tab[p];
			test_random_streams(105);
		end
		wait_drain();
		repeat (2200) @(posedge clk);
		if (fail_count == 0 && decoded_q.size() == 0)
			$display("prefix_code_bit_decoder_unit regression: pass");
		else
			$display("prefix_code_bit_decoder_unit regression: fail");
		$finish;
	end

	initial begin
		#40000000;
		$display("prefix_code_bit_decoder_unit regression: fail");
		$finish;
	end

endmodule
